@@ sv/assert_macros.svh @@
// Assertion helpers shared by the checker files.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ sv/cfed_pkg.sv @@
package cfed_pkg;

    // Request kinds carried in the input tuser
    localparam logic [1:0] REQ_APPEND  = 2'd0;
    localparam logic [1:0] REQ_COMPARE = 2'd1;
    localparam logic [1:0] REQ_FINISH  = 2'd2;

    // Cost values reach at most 256 for the largest supported string length
    localparam int unsigned COST_W = 9;

    localparam logic [6:0] MAX_EDITS_RESET = 7'd3;
    localparam logic [6:0] DIST_FIELD_MAX  = 7'd127;

    // Token handed from cell to cell: one second-string byte on its way along
    // the row, with the left neighbor's old (diag) and updated (left) cost.
    typedef struct packed {
        logic              valid;
        logic [7:0]        ch;
        logic [COST_W-1:0] diag;
        logic [COST_W-1:0] left;
    } t_token;

    // Fold ASCII upper-case letters to lower case, leave every other byte
    function automatic logic [7:0] fold_char(input logic [7:0] b);
        logic [7:0] res;
        res = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            res = b + 8'h20;
        end
        return res;
    endfunction

endpackage

@@ sv/cfed_cell.sv @@
module cfed_cell #(
    parameter int unsigned CELL_IDX = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_clear,
    input  logic [7:0]      i_char,
    input  cfed_pkg::t_token i_tok,
    output cfed_pkg::t_token o_tok
);
    import cfed_pkg::*;

    logic              r_act;
    logic [7:0]        r_pat;
    logic [COST_W-1:0] r_cost;
    t_token            r_tok;
    t_token            n_tok;

    logic [COST_W-1:0] above_inc;
    logic [COST_W-1:0] left_inc;
    logic [COST_W-1:0] sub_cost;
    logic [COST_W-1:0] best;

    // Edit step: min of insertion, deletion and substitution
    always_comb begin
        above_inc = r_cost + COST_W'(1);
        left_inc  = i_tok.left + COST_W'(1);
        sub_cost  = i_tok.diag + COST_W'(r_pat != i_tok.ch);
        best      = left_inc;
        if (above_inc < best) begin
            best = above_inc;
        end
        if (sub_cost < best) begin
            best = sub_cost;
        end
    end

    // Forward the token; an idle cell passes the running cost unchanged
    always_comb begin
        n_tok = i_tok;
        if (r_act) begin
            n_tok.diag = r_cost;
            n_tok.left = best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_clear) begin
                r_act <= 1'b0;
            end else if (i_load) begin
                r_act <= 1'b1;
            end
        end
    end

    // Pattern byte and cost entry: set on load, update as tokens pass an active cell
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat  <= fold_char(i_char);
            r_cost <= COST_W'(CELL_IDX);
        end else if (i_tok.valid && r_act) begin
            r_cost <= best;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/case_folded_edit_distance_unit.sv @@
// Append and compare transfers are taken one per cycle while no finish is pending;
// each compare byte walks the cell row one cell per cycle, so the last column
// cost is captured as the byte leaves the last cell.
// A finish transfer holds tready low until the row drains and the result is
// registered, later while an older result waits.
// Reset (synchronous, active low) clears the pair state and sets max_edits to 3.
module case_folded_edit_distance_unit #(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,   // max_edits
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] char_byte
    input  logic [1:0]  i_s_tuser,     // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata      // [6:0] distance, [7] within_limit, [8] dropped
);
    import cfed_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

    logic [LEN_W-1:0]  r_plen;
    logic [LEN_W-1:0]  r_slen;
    logic              r_drop;
    logic [6:0]        r_max_edits;
    logic              r_fin_pend;
    logic [COST_W-1:0] r_dist;
    logic              r_ovalid;
    logic [6:0]        r_o_dist;
    logic              r_o_within;
    logic              r_o_drop;

    logic   acc, is_app, is_cmp, is_fin, app_ok, cmp_ok, busy, emit;
    t_token w_tok [MAX_LEN+1];

    // Decode the accepted transfer
    always_comb begin
        acc    = i_s_tvalid && o_s_tready;
        is_app = acc && (i_s_tuser == REQ_APPEND);
        is_cmp = acc && (i_s_tuser == REQ_COMPARE);
        is_fin = acc && (i_s_tuser == REQ_FINISH);
        app_ok = is_app && (r_slen == '0) && (r_plen != LEN_W'(MAX_LEN));
        cmp_ok = is_cmp && (r_slen != LEN_W'(MAX_LEN));
    end

    // Inject a compare byte at the head of the row with the column-zero costs
    always_comb begin
        w_tok[0].valid = cmp_ok;
        w_tok[0].ch    = fold_char(i_s_tdata);
        w_tok[0].diag  = COST_W'(r_slen);
        w_tok[0].left  = COST_W'(r_slen) + COST_W'(1);
    end

    // Row of cells, one per pattern position
    for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
        cfed_cell #(.CELL_IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (app_ok && (r_plen == LEN_W'(k - 1))),
            .i_clear (emit),
            .i_char  (i_s_tdata),
            .i_tok   (w_tok[k-1]),
            .o_tok   (w_tok[k])
        );
    end

    // Row is busy while any token is still in flight
    always_comb begin
        busy = 1'b0;
        for (int k = 1; k <= MAX_LEN; k++) begin
            busy = busy | w_tok[k].valid;
        end
        emit = r_fin_pend && !busy && (!r_ovalid || i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_slen      <= '0;
            r_drop      <= 1'b0;
            r_max_edits <= MAX_EDITS_RESET;
            r_fin_pend  <= 1'b0;
            r_dist      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_edits <= i_cfg_wdata;
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            // Track lengths; the distance with no compare bytes is the pattern length
            if (app_ok) begin
                r_plen <= r_plen + LEN_W'(1);
                r_dist <= COST_W'(r_plen) + COST_W'(1);
            end
            if (cmp_ok) begin
                r_slen <= r_slen + LEN_W'(1);
            end
            if ((is_app && !app_ok) || (is_cmp && !cmp_ok)) begin
                r_drop <= 1'b1;
            end
            // Capture the last column cost as each token leaves the row
            if (w_tok[MAX_LEN].valid) begin
                r_dist <= w_tok[MAX_LEN].left;
            end
            if (is_fin) begin
                r_fin_pend <= 1'b1;
            end
            // Report and clear the pair
            if (emit) begin
                r_ovalid   <= 1'b1;
                r_o_dist   <= (r_dist > COST_W'(DIST_FIELD_MAX)) ? DIST_FIELD_MAX
                                                                 : r_dist[6:0];
                r_o_within <= (r_dist <= COST_W'(r_max_edits));
                r_o_drop   <= r_drop;
                r_plen     <= '0;
                r_slen     <= '0;
                r_drop     <= 1'b0;
                r_dist     <= '0;
                r_fin_pend <= 1'b0;
            end
        end
    end

    assign o_s_tready = !r_fin_pend;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_o_drop, r_o_within, r_o_dist};

endmodule

@@ sv/cfed_checker.sv @@
`include "assert_macros.svh"

module cfed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [6:0]  i_cfg_wdata,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);
    import cfed_pkg::*;

    // A stalled result holds
    `CHK_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // A finish transfer blocks the input while the row drains
    `CHK_NEXT(a_fin_block, i_s_tvalid && o_s_tready && (i_s_tuser == REQ_FINISH), !o_s_tready)
    // Padding bits of the result stay zero
    `CHK_IMPL(a_pad_zero, o_m_tvalid, o_m_tdata[15:9] == 7'd0)
    // A zero distance is always within the limit
    `CHK_IMPL(a_zero_within, o_m_tvalid && (o_m_tdata[6:0] == 7'd0), o_m_tdata[7])

endmodule

bind case_folded_edit_distance_unit cfed_checker u_cfed_checker (.*);
